>>> src/spi_pkg.sv
// ----------------------------------------------------------------------------
// spi_pkg
// Shared widths, types and register codes of the segment/plane intersection.
// ----------------------------------------------------------------------------
package spi_pkg;

	localparam int F  = 16;            // fraction bits
	localparam int W  = 32;            // coordinate width
	localparam int DW = W + 1;         // coordinate difference
	localparam int PW = W + DW;        // one product
	localparam int SW = PW + 2;        // dot product of three terms
	localparam int NW = SW + F;        // scaled numerator magnitude
	localparam int QW = W + 1;         // quotient bits developed
	localparam int RW = SW + 1;        // partial remainder
	localparam int CW = PW + 1;        // hit coordinate before clamp

	localparam logic [QW-1:0] T_POS = {{(QW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic [QW-1:0] T_NEG = {{(QW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

	typedef enum logic [2:0] {
		REG_NX = 3'd0,
		REG_NY = 3'd1,
		REG_NZ = 3'd2,
		REG_PX = 3'd3,
		REG_PY = 3'd4,
		REG_PZ = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [2:0][W-1:0]  a;
		logic [2:0][DW-1:0] d;
	} seg_t;

	typedef struct packed {
		logic          neg;
		logic          par;
		logic          ovf;
		logic [QW-1:0] q;
	} quo_t;

endpackage

>>> src/segment_plane_intersection.sv
// ----------------------------------------------------------------------------
// segment_plane_intersection
// Fixed-point Q16.16 intersection of a line segment with a configured plane.
// ----------------------------------------------------------------------------
// Accepts one segment per clock unless the output stalls; each segment gets
// one result, in order, after 3 stages of exact dot products, 1 divider prep
// stage, 33 divider stages (one quotient bit each) and 3 stages that clamp t,
// scale the direction and add the start point. A stall on the result side
// freezes the whole pipeline; write the plane only while the pipeline is empty.
module segment_plane_intersection
	import spi_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [191:0] s_tdata,   // start_x, start_y, start_z, end_x, end_y, end_z
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,   // hit_x, hit_y, hit_z
	output logic [1:0]   m_tuser    // parallel, saturated
);

	logic [2:0][W-1:0] nrm_q, pnt_q;
	logic [2:0][W-1:0] a, b, hit;
	logic              en;
	logic              dot_v, div_v;
	logic [SW-1:0]     num, den;
	seg_t              dot_seg, div_seg;
	quo_t              quo;
	logic              par, sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nrm_q <= '0;
			pnt_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_NX: nrm_q[0] <= cfg_data;
				REG_NY: nrm_q[1] <= cfg_data;
				REG_NZ: nrm_q[2] <= cfg_data;
				REG_PX: pnt_q[0] <= cfg_data;
				REG_PY: pnt_q[1] <= cfg_data;
				REG_PZ: pnt_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a[i] = s_tdata[i*W +: W];
			b[i] = s_tdata[(3+i)*W +: W];
		end
	end

	spi_dot u_dot (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(s_tvalid),
		.a(a), .b(b), .n(nrm_q), .p(pnt_q),
		.out_valid(dot_v), .num(num), .den(den), .seg(dot_seg)
	);

	spi_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(dot_v),
		.num(num), .den(den), .in_seg(dot_seg),
		.out_valid(div_v), .quo(quo), .out_seg(div_seg)
	);

	spi_hit u_hit (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(div_v),
		.quo(quo), .seg(div_seg),
		.out_valid(m_tvalid), .hit(hit), .par(par), .sat(sat)
	);

	assign m_tdata = {hit[2], hit[1], hit[0]};
	assign m_tuser = {sat, par};

endmodule

>>> src/spi_dot.sv
// ----------------------------------------------------------------------------
// spi_dot
// Three stages: differences, products with the normal, exact dot sums.
// ----------------------------------------------------------------------------
module spi_dot
	import spi_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [2:0][W-1:0]  a,
	input  logic [2:0][W-1:0]  b,
	input  logic [2:0][W-1:0]  n,
	input  logic [2:0][W-1:0]  p,
	output logic               out_valid,
	output logic [SW-1:0]      num,
	output logic [SW-1:0]      den,
	output seg_t               seg
);

	logic              v_s1, v_s2, v_s3;
	seg_t              seg_s1, seg_s2, seg_s3;
	logic [2:0][DW-1:0] pa_s1;
	logic [2:0][PW-1:0] pden_s2, pnum_s2;
	logic [SW-1:0]     num_s3, den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				seg_s1.a[i] <= a[i];
				seg_s1.d[i] <= {b[i][W-1], b[i]} - {a[i][W-1], a[i]};
				pa_s1[i]    <= {p[i][W-1], p[i]} - {a[i][W-1], a[i]};
			end
			seg_s2 <= seg_s1;
			for (int i = 0; i < 3; i++) begin
				pden_s2[i] <= $signed({{(PW-W){n[i][W-1]}}, n[i]})
					* $signed({{(PW-DW){seg_s1.d[i][DW-1]}}, seg_s1.d[i]});
				pnum_s2[i] <= $signed({{(PW-W){n[i][W-1]}}, n[i]})
					* $signed({{(PW-DW){pa_s1[i][DW-1]}}, pa_s1[i]});
			end
			seg_s3 <= seg_s2;
			den_s3 <= {{(SW-PW){pden_s2[0][PW-1]}}, pden_s2[0]}
				+ {{(SW-PW){pden_s2[1][PW-1]}}, pden_s2[1]}
				+ {{(SW-PW){pden_s2[2][PW-1]}}, pden_s2[2]};
			num_s3 <= {{(SW-PW){pnum_s2[0][PW-1]}}, pnum_s2[0]}
				+ {{(SW-PW){pnum_s2[1][PW-1]}}, pnum_s2[1]}
				+ {{(SW-PW){pnum_s2[2][PW-1]}}, pnum_s2[2]};
		end
	end

	assign out_valid = v_s3;
	assign num       = num_s3;
	assign den       = den_s3;
	assign seg       = seg_s3;

endmodule

>>> src/spi_div.sv
// ----------------------------------------------------------------------------
// spi_div
// Signed fixed-point divide: a prep stage, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module spi_div
	import spi_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [SW-1:0] num,
	input  logic [SW-1:0] den,
	input  seg_t          in_seg,
	output logic          out_valid,
	output quo_t          quo,
	output seg_t          out_seg
);

	logic [SW-1:0] nabs, dabs;
	logic [NW-1:0] nsc;

	logic          vld_s  [0:QW];
	logic [RW-1:0] rem_s  [0:QW];
	logic [QW-1:0] nlo_s  [0:QW];
	logic [QW-1:0] quo_s  [0:QW];
	logic [SW-1:0] dv_s   [0:QW];
	logic          neg_s  [0:QW];
	logic          par_s  [0:QW];
	logic          ovf_s  [0:QW];
	seg_t          seg_s  [0:QW];

	always_comb begin
		nabs = num[SW-1] ? -num : num;
		dabs = den[SW-1] ? -den : den;
		nsc  = {nabs, {F{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {{(RW-(NW-QW)){1'b0}}, nsc[NW-1:QW]};
			nlo_s[0] <= nsc[QW-1:0];
			quo_s[0] <= '0;
			dv_s[0]  <= dabs;
			neg_s[0] <= num[SW-1] ^ den[SW-1];
			par_s[0] <= (den == '0);
			ovf_s[0] <= ({{(RW-(NW-QW)){1'b0}}, nsc[NW-1:QW]} >= {1'b0, dabs});
			seg_s[0] <= in_seg;
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_step
		logic [RW-1:0] shf;
		logic          ge;

		always_comb begin
			shf = {rem_s[k-1][RW-2:0], nlo_s[k-1][QW-k]};
			ge  = (shf >= {1'b0, dv_s[k-1]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? shf - {1'b0, dv_s[k-1]} : shf;
				quo_s[k] <= {quo_s[k-1][QW-2:0], ge};
				nlo_s[k] <= nlo_s[k-1];
				dv_s[k]  <= dv_s[k-1];
				neg_s[k] <= neg_s[k-1];
				par_s[k] <= par_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
				seg_s[k] <= seg_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign quo.neg   = neg_s[QW];
	assign quo.par   = par_s[QW];
	assign quo.ovf   = ovf_s[QW];
	assign quo.q     = quo_s[QW];
	assign out_seg   = seg_s[QW];

endmodule

>>> src/spi_hit.sv
// ----------------------------------------------------------------------------
// spi_hit
// Clamp t, scale the direction by t and add the start point, with saturation.
// ----------------------------------------------------------------------------
module spi_hit
	import spi_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  quo_t              quo,
	input  seg_t              seg,
	output logic              out_valid,
	output logic [2:0][W-1:0] hit,
	output logic              par,
	output logic              sat
);

	logic               big;
	logic [QW-1:0]      mag, tq;
	logic               v_s1, v_s2, v_s3;
	logic [W-1:0]       t_s1;
	logic               sat_s1, sat_s2, par_s1, par_s2;
	seg_t               seg_s1;
	logic [2:0][W-1:0]  a_s2;
	logic [2:0][PW-1:0] prod_s2;
	logic [2:0][CW-1:0] sum;
	logic [2:0]         hi, lo;
	logic [2:0][W-1:0]  hit_s3;
	logic               par_s3, sat_s3;

	localparam logic signed [CW-1:0] C_MAX = CW'(2**(W-1)-1);
	localparam logic signed [CW-1:0] C_MIN = ~C_MAX;

	always_comb begin
		big = quo.ovf || (quo.neg ? (quo.q > T_NEG) : (quo.q > T_POS));
		mag = big ? (quo.neg ? T_NEG : T_POS) : quo.q;
		tq  = quo.neg ? -mag : mag;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum[i] = {{(CW-W){a_s2[i][W-1]}}, a_s2[i]}
				+ CW'($signed(prod_s2[i]) >>> F);
			hi[i]  = $signed(sum[i]) > C_MAX;
			lo[i]  = $signed(sum[i]) < C_MIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1   <= tq[W-1:0];
			sat_s1 <= big;
			par_s1 <= quo.par;
			seg_s1 <= seg;

			for (int i = 0; i < 3; i++) begin
				prod_s2[i] <= $signed({{(PW-DW){seg_s1.d[i][DW-1]}}, seg_s1.d[i]})
					* $signed({{(PW-W){t_s1[W-1]}}, t_s1});
			end
			a_s2   <= seg_s1.a;
			sat_s2 <= sat_s1;
			par_s2 <= par_s1;

			for (int i = 0; i < 3; i++) begin
				if (par_s2) begin
					hit_s3[i] <= '0;
				end else if (hi[i]) begin
					hit_s3[i] <= C_MAX[W-1:0];
				end else if (lo[i]) begin
					hit_s3[i] <= C_MIN[W-1:0];
				end else begin
					hit_s3[i] <= sum[i][W-1:0];
				end
			end
			par_s3 <= par_s2;
			sat_s3 <= !par_s2 && (sat_s2 || (|hi) || (|lo));
		end
	end

	assign out_valid = v_s3;
	assign hit       = hit_s3;
	assign par       = par_s3;
	assign sat       = sat_s3;

endmodule

>>> src/spi_checker.sv
// ----------------------------------------------------------------------------
// spi_checker
// Port-level checks of the segment/plane intersection.
// ----------------------------------------------------------------------------
module spi_checker
	import spi_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [95:0]  m_tdata,
	input logic [1:0]   m_tuser
);

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	a_ready_track: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken while output stalled");

	a_parallel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && !m_tuser[1]))
		else $error("parallel result not zero");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

endmodule

bind segment_plane_intersection spi_checker u_spi_checker (
	.clk(clk), .arst_n(arst_n),
	.s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .m_tuser(m_tuser)
);
